// ===== src/cpm_pkg.sv =====
// Shared types and constants for the complex polynomial multiplier.
package cpm_pkg;

    // Width of a product coefficient component, Q21.16.
    localparam int PROD_W = 37;

    typedef logic signed [PROD_W-1:0] cpm_sum_t;

    // Per-cycle command to every cell of the chain.
    typedef struct packed {
        logic step;       // shift partial sums one place towards the head
        logic clear;      // zero all partial sums
        logic zero_prod;  // flush step: cells add nothing
    } cpm_chain_ctl_t;

endpackage

// ===== src/cpm_cell.sv =====
// One tap cell: holds a tap, its registered complex product and a partial sum.
module cpm_cell #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cpm_pkg::cpm_chain_ctl_t              ctl,
    input  logic signed [COEF_WIDTH-1:0]         x_re,
    input  logic signed [COEF_WIDTH-1:0]         x_im,
    input  logic                                 tap_we,
    input  logic                                 prod_we,
    input  logic                                 active,
    input  cpm_pkg::cpm_sum_t                    sum_in_re,
    input  cpm_pkg::cpm_sum_t                    sum_in_im,
    output cpm_pkg::cpm_sum_t                    sum_out_re,
    output cpm_pkg::cpm_sum_t                    sum_out_im
);
    import cpm_pkg::*;

    localparam int MW = 2 * COEF_WIDTH + 1;

    logic signed [COEF_WIDTH-1:0] tap_re_reg;
    logic signed [COEF_WIDTH-1:0] tap_im_reg;
    logic signed [MW-1:0]         mul_re;
    logic signed [MW-1:0]         mul_im;
    cpm_sum_t                     prod_re_next;
    cpm_sum_t                     prod_im_next;
    cpm_sum_t                     prod_re_reg;
    cpm_sum_t                     prod_im_reg;
    cpm_sum_t                     partial_re_reg;
    cpm_sum_t                     partial_im_reg;
    cpm_sum_t                     partial_re_next;
    cpm_sum_t                     partial_im_next;

    always_comb
    begin
        mul_re = MW'(x_re) * MW'(tap_re_reg) - MW'(x_im) * MW'(tap_im_reg);
        mul_im = MW'(x_re) * MW'(tap_im_reg) + MW'(x_im) * MW'(tap_re_reg);
        // idle cells above the tap count contribute zero
        prod_re_next = active ? PROD_W'(mul_re) : '0;
        prod_im_next = active ? PROD_W'(mul_im) : '0;
    end

    assign sum_out_re = partial_re_reg + (ctl.zero_prod ? cpm_sum_t'(0) : prod_re_reg);
    assign sum_out_im = partial_im_reg + (ctl.zero_prod ? cpm_sum_t'(0) : prod_im_reg);

    always_comb
    begin
        partial_re_next = partial_re_reg;
        partial_im_next = partial_im_reg;
        if (ctl.clear)
        begin
            partial_re_next = '0;
            partial_im_next = '0;
        end
        else if (ctl.step)
        begin
            partial_re_next = sum_in_re;
            partial_im_next = sum_in_im;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_re_reg <= x_re;
            tap_im_reg <= x_im;
        end
        if (prod_we)
        begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_re_reg <= '0;
            partial_im_reg <= '0;
        end
        else
        begin
            partial_re_reg <= partial_re_next;
            partial_im_reg <= partial_im_next;
        end
    end

endmodule

// ===== src/complex_polynomial_multiply_core.sv =====
// Top level: streaming complex polynomial multiplier built as a chain of tap cells.
// A streamed item's products are registered in the cells; its head sum then enters the output register.
// Throughput: one item per cycle while the output does not stall; a streamed item marked last holds the chain
// while the pending sums drain, one per cycle unless the output stalls, through cell 0.
// Loads give no result; a load opening a new set clears the chain.
// Reset clears tap count, partial sums, overflow and all valid state; taps stay undefined.
module complex_polynomial_multiply_core #(
    parameter int MAX_TAPS   = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic signed [COEF_WIDTH-1:0]  coef_re,
    input  logic signed [COEF_WIDTH-1:0]  coef_im,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cpm_pkg::cpm_sum_t             prod_re,
    output cpm_pkg::cpm_sum_t             prod_im,
    output logic                          run_end,
    output logic                          overflow
);
    import cpm_pkg::*;

    localparam int CNT_W = $clog2(MAX_TAPS + 1);

    // tap store bookkeeping
    logic [CNT_W-1:0] tap_count_reg, tap_count_next;
    logic             load_closed_reg, load_closed_next;
    logic             overflow_reg, overflow_next;

    // token waiting between the product registers and the chain
    logic             p_valid_reg, p_valid_next;
    logic             p_clear_reg, p_clear_next;
    logic             p_last_reg, p_last_next;
    logic [CNT_W-1:0] p_rem_reg, p_rem_next;
    logic             p_ovf_reg, p_ovf_next;

    // drain of the remaining sums after a last item
    logic             flush_reg, flush_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             flush_ovf_reg, flush_ovf_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    cpm_sum_t         out_re_reg;
    cpm_sum_t         out_im_reg;
    logic             run_end_reg, run_end_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             accept;
    logic             load_acc;
    logic             strm_acc;
    logic             out_free;
    logic             acc_fire;
    logic             flush_fire;
    logic [CNT_W-1:0] wr_idx;
    logic             store_full;
    cpm_chain_ctl_t   ctl;

    logic [MAX_TAPS-1:0] tap_we;
    logic [MAX_TAPS-1:0] active;
    cpm_sum_t            chain_re [0:MAX_TAPS];
    cpm_sum_t            chain_im [0:MAX_TAPS];

    assign out_free   = !out_valid_reg || !out_stall;
    // a clear item needs no output slot
    assign acc_fire   = p_valid_reg && !flush_reg && (p_clear_reg || out_free);
    assign flush_fire = flush_reg && out_free;
    assign in_stall   = p_valid_reg && !acc_fire;
    assign accept     = in_valid && !in_stall;
    assign load_acc   = accept && !mode;
    assign strm_acc   = accept && mode;

    // a load that opens a new set writes entry 0
    assign wr_idx     = load_closed_reg ? '0 : tap_count_reg;
    assign store_full = (wr_idx == CNT_W'(MAX_TAPS));

    always_comb
    begin
        ctl.step      = (acc_fire && !p_clear_reg) || flush_fire;
        ctl.clear     = acc_fire && p_clear_reg;
        ctl.zero_prod = flush_reg;
    end

    always_comb
    begin
        for (int j = 0; j < MAX_TAPS; j++)
        begin
            tap_we[j] = load_acc && !store_full && (wr_idx == CNT_W'(j));
            active[j] = CNT_W'(j) < tap_count_reg;
        end
    end

    always_comb
    begin
        tap_count_next   = tap_count_reg;
        load_closed_next = load_closed_reg;
        overflow_next    = overflow_reg;
        p_valid_next     = p_valid_reg && !acc_fire;
        p_clear_next     = p_clear_reg;
        p_last_next      = p_last_reg;
        p_rem_next       = p_rem_reg;
        p_ovf_next       = p_ovf_reg;
        flush_next       = flush_reg;
        rem_next         = rem_reg;
        flush_ovf_next   = flush_ovf_reg;
        out_valid_next   = out_valid_reg && out_stall;
        run_end_next     = run_end_reg;
        out_ovf_next     = out_ovf_reg;

        if (load_acc)
        begin
            if (store_full)
                overflow_next = 1'b1;
            else
                tap_count_next = wr_idx + CNT_W'(1);
            if (store_full && load_closed_reg)
                tap_count_next = '0;
            load_closed_next = last;
            if (load_closed_reg)
            begin
                // new set: pending sums are abandoned
                p_valid_next = 1'b1;
                p_clear_next = 1'b1;
            end
        end
        else if (strm_acc)
        begin
            p_valid_next = 1'b1;
            p_clear_next = 1'b0;
            p_last_next  = last;
            p_rem_next   = (tap_count_reg == '0) ? '0 : tap_count_reg - CNT_W'(1);
            p_ovf_next   = overflow_reg;
        end

        if (acc_fire && !p_clear_reg)
        begin
            out_valid_next = 1'b1;
            run_end_next   = p_last_reg && (p_rem_reg == '0);
            out_ovf_next   = p_ovf_reg;
            if (p_last_reg && (p_rem_reg != '0))
            begin
                flush_next     = 1'b1;
                rem_next       = p_rem_reg;
                flush_ovf_next = p_ovf_reg;
            end
        end
        else if (flush_fire)
        begin
            out_valid_next = 1'b1;
            run_end_next   = (rem_reg == CNT_W'(1));
            out_ovf_next   = flush_ovf_reg;
            rem_next       = rem_reg - CNT_W'(1);
            if (rem_reg == CNT_W'(1))
                flush_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg   <= '0;
            load_closed_reg <= 1'b1;
            overflow_reg    <= 1'b0;
            p_valid_reg     <= 1'b0;
            p_clear_reg     <= 1'b0;
            p_last_reg      <= 1'b0;
            p_rem_reg       <= '0;
            p_ovf_reg       <= 1'b0;
            flush_reg       <= 1'b0;
            rem_reg         <= '0;
            flush_ovf_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            run_end_reg     <= 1'b0;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            tap_count_reg   <= tap_count_next;
            load_closed_reg <= load_closed_next;
            overflow_reg    <= overflow_next;
            p_valid_reg     <= p_valid_next;
            p_clear_reg     <= p_clear_next;
            p_last_reg      <= p_last_next;
            p_rem_reg       <= p_rem_next;
            p_ovf_reg       <= p_ovf_next;
            flush_reg       <= flush_next;
            rem_reg         <= rem_next;
            flush_ovf_reg   <= flush_ovf_next;
            out_valid_reg   <= out_valid_next;
            run_end_reg     <= run_end_next;
            out_ovf_reg     <= out_ovf_next;
        end
    end

    // head of the chain feeds the output register
    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            out_re_reg <= chain_re[0];
            out_im_reg <= chain_im[0];
        end
    end

    // the cell past the top shifts in zero
    assign chain_re[MAX_TAPS] = '0;
    assign chain_im[MAX_TAPS] = '0;

    for (genvar j = 0; j < MAX_TAPS; j++)
    begin : g_cell
        cpm_cell #(
            .COEF_WIDTH (COEF_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .x_re       (coef_re),
            .x_im       (coef_im),
            .tap_we     (tap_we[j]),
            .prod_we    (strm_acc),
            .active     (active[j]),
            .sum_in_re  (chain_re[j+1]),
            .sum_in_im  (chain_im[j+1]),
            .sum_out_re (chain_re[j]),
            .sum_out_im (chain_im[j])
        );
    end

    assign out_valid = out_valid_reg;
    assign prod_re   = out_re_reg;
    assign prod_im   = out_im_reg;
    assign run_end   = run_end_reg;
    assign overflow  = out_ovf_reg;

    // a drain always has at least one sum left to send
    a_flush_rem: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> rem_reg != '0)
        else $error("drain running with nothing left");

    a_tap_count: assert property (@(posedge clk) disable iff (!rst_n)
        tap_count_reg <= CNT_W'(MAX_TAPS))
        else $error("tap count beyond capacity");

    // a waiting item must not slip past an unfinished drain
    a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg && p_valid_reg |-> in_stall && !ctl.clear)
        else $error("chain disturbed during drain");

    // the last sum of a drain ends the run
    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        flush_fire && rem_reg == CNT_W'(1) |=> out_valid && run_end && !flush_reg)
        else $error("drain ended without run end");

endmodule

// ===== bench/complex_polynomial_multiply_core_tb.sv =====
// Self-checking bench for the streaming complex polynomial multiplier core.
`timescale 1ns / 100ps

module complex_polynomial_multiply_core_tb;
    import cpm_pkg::*;

    localparam int N_TAPS      = 16;
    localparam int COEF_W      = 16;
    localparam int RAND_ITEMS  = 300;
    localparam int QUIET_ITEMS = 50;    // closing stretch run with no idling
    localparam int TAIL_CYCLES = 24;
    localparam int DRAIN_LIMIT = 4000;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_STREAM = 1'b1;

    localparam logic signed [COEF_W-1:0] C_MIN = 16'sh8000;
    localparam logic signed [COEF_W-1:0] C_MAX = 16'sh7fff;
    localparam logic signed [COEF_W-1:0] C_ONE = 16'sh0100;   // 1.0 in Q8.8

    typedef struct {
        cpm_sum_t re;
        cpm_sum_t im;
        logic     run_end;
        logic     ovf;
    } prod_coef_t;

    // Transposed-form convolution tracker: taps of B, pending sums of A*B and
    // the product coefficients still owed by the core, oldest first.
    class poly_product_checker;
        logic signed [COEF_W-1:0] tap_re [N_TAPS];
        logic signed [COEF_W-1:0] tap_im [N_TAPS];
        int         taps_held;
        bit         set_closed;
        longint     sum_re [N_TAPS];
        longint     sum_im [N_TAPS];
        bit         ovf_sticky;
        prod_coef_t coefs_due [$];
        int         errors;

        function new();
            taps_held  = 0;
            set_closed = 1'b1;
            ovf_sticky = 1'b0;
            errors     = 0;
            for (int j = 0; j < N_TAPS; j++)
            begin
                sum_re[j] = 0;
                sum_im[j] = 0;
            end
        endfunction

        function void flag(string msg);
            errors++;
            $display("%0t ns: %s", $time, msg);
        endfunction

        // Head sum leaves as a coefficient; the rest move one place down.
        function void emit_head(int n, bit is_end);
            prod_coef_t c;
            int         j;
            c.re      = sum_re[0][PROD_W-1:0];
            c.im      = sum_im[0][PROD_W-1:0];
            c.run_end = is_end;
            c.ovf     = ovf_sticky;
            coefs_due.push_back(c);
            for (j = 0; j + 1 < n; j++)
            begin
                sum_re[j] = sum_re[j+1];
                sum_im[j] = sum_im[j+1];
            end
            sum_re[n-1] = 0;
            sum_im[n-1] = 0;
        endfunction

        function void absorb_item(logic m, logic signed [COEF_W-1:0] xr,
                                  logic signed [COEF_W-1:0] xi, logic lst);
            longint ar, ai, br, bi;
            int     n, j;
            if (m == MODE_LOAD)
            begin
                if (set_closed)
                begin
                    taps_held  = 0;
                    set_closed = 1'b0;
                    for (j = 0; j < N_TAPS; j++)
                    begin
                        sum_re[j] = 0;
                        sum_im[j] = 0;
                    end
                end
                if (taps_held < N_TAPS)
                begin
                    tap_re[taps_held] = xr;
                    tap_im[taps_held] = xi;
                    taps_held++;
                end
                else
                    ovf_sticky = 1'b1;
                if (lst)
                    set_closed = 1'b1;
            end
            else
            begin
                ar = xr;
                ai = xi;
                for (j = 0; j < taps_held; j++)
                begin
                    br = tap_re[j];
                    bi = tap_im[j];
                    sum_re[j] += ar * br - ai * bi;
                    sum_im[j] += ar * bi + ai * br;
                end
                n = (taps_held == 0) ? 1 : taps_held;
                if (!lst)
                    emit_head(n, 1'b0);
                else
                    for (j = 0; j < n; j++)
                        emit_head(n, j == n - 1);
            end
        endfunction

        function void cmp(string fld, logic signed [63:0] want, logic signed [63:0] got);
            if (got !== want)
                flag($sformatf("%s expected %0d actual %0d", fld, want, got));
        endfunction

        function void match_coef(cpm_sum_t re, cpm_sum_t im, logic rend, logic ovf);
            prod_coef_t w;
            if (coefs_due.size() == 0)
            begin
                flag($sformatf("coefficient with none due: expected nothing actual re %0d im %0d",
                               re, im));
                return;
            end
            w = coefs_due.pop_front();
            cmp("prod_re", w.re, re);
            cmp("prod_im", w.im, im);
            cmp("run_end", w.run_end, rend);
            cmp("overflow", w.ovf, ovf);
        endfunction

        function void settle();
            if (coefs_due.size() != 0)
                flag($sformatf("coefficients outstanding: expected %0d more actual 0",
                               coefs_due.size()));
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     mode;
    logic signed [COEF_W-1:0] coef_re;
    logic signed [COEF_W-1:0] coef_im;
    logic                     last;
    logic                     out_valid;
    logic                     out_stall;
    cpm_sum_t                 prod_re;
    cpm_sum_t                 prod_im;
    logic                     run_end;
    logic                     overflow;

    bit                  idle_on = 1'b1;   // random gaps and stalls allowed
    int                  items_sent;
    int                  stall_left;
    poly_product_checker book = new();

    complex_polynomial_multiply_core #(
        .MAX_TAPS   (N_TAPS),
        .COEF_WIDTH (COEF_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .coef_re   (coef_re),
        .coef_im   (coef_im),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .prod_re   (prod_re),
        .prod_im   (prod_im),
        .run_end   (run_end),
        .overflow  (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop, well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Receiver: stall in random bursts while idling is allowed.
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 12);
            out_stall <= (stall_left > 0);
        end
    end

    // Output side: every product coefficient taken at an edge is checked.
    // Values read just after the edge are the ones the core presented there.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.match_coef(prod_re, prod_im, run_end, overflow);
    end

    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            default: return r[COEF_W-1:0];
        endcase
    endfunction

    // Mostly short sets keep runs quick; now and then a full store.
    function automatic int pick_taps();
        return ($urandom_range(0, 7) == 0) ? N_TAPS : $urandom_range(1, 6);
    endfunction

    // One item on the input channel. Valid is only lowered for a gap, so a
    // back-to-back item never sees valid dropped and raised in one step.
    task automatic send_item(logic m, logic signed [COEF_W-1:0] xr,
                             logic signed [COEF_W-1:0] xi, logic lst);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        coef_re  <= xr;
        coef_im  <= xi;
        last     <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.absorb_item(m, xr, xi, lst);
        items_sent++;
    endtask

    task automatic load_set(int n, bit close);
        for (int k = 0; k < n; k++)
            send_item(MODE_LOAD, rand_coef(), rand_coef(), close && k == n - 1);
    endtask

    task automatic stream_poly(int n, bit close);
        for (int k = 0; k < n; k++)
            send_item(MODE_STREAM, rand_coef(), rand_coef(), close && k == n - 1);
    endtask

    // Sender holds off until the core owes nothing.
    task automatic drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.coefs_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int base;
        int guard;
        int k;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_LOAD;
        coef_re    = '0;
        coef_im    = '0;
        last       = 1'b0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed ---
        // empty store behaves as one zero tap
        send_item(MODE_STREAM, C_MIN, C_MAX, 1'b1);
        // stream against a set still open, then grow it
        send_item(MODE_LOAD,   C_MIN, C_MIN, 1'b0);
        send_item(MODE_STREAM, C_MAX, C_MIN, 1'b0);
        send_item(MODE_LOAD,   C_MAX, C_MAX, 1'b1);
        // unfinished run, abandoned by the next set
        send_item(MODE_STREAM, C_MIN, C_MIN, 1'b0);
        send_item(MODE_LOAD,   C_ONE, '0,    1'b1);
        send_item(MODE_STREAM, C_MAX, C_MAX, 1'b1);
        drain_pause();
        // fill all taps and push one more: dropped, overflow sticks from here
        for (k = 0; k <= N_TAPS; k++)
            send_item(MODE_LOAD, (k % 2) ? C_MAX : C_MIN, C_MIN, k == N_TAPS);
        send_item(MODE_STREAM, C_MIN, C_MIN, 1'b0);
        send_item(MODE_STREAM, C_MAX, C_MAX, 1'b1);   // full-depth flush

        // --- random: mostly well-formed set/run sequences ---
        base = items_sent;
        while (items_sent - base < RAND_ITEMS)
        begin
            if (items_sent - base >= RAND_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            case ($urandom_range(0, 9)) inside
                [0:4]:
                begin
                    load_set(pick_taps(), 1'b1);
                    repeat ($urandom_range(1, 3))
                        stream_poly($urandom_range(1, 6), 1'b1);
                end
                5: stream_poly($urandom_range(1, 8), 1'b1);   // reuse current set
                6:
                begin
                    // taps arrive while a run is under way
                    load_set($urandom_range(1, 4), 1'b0);
                    stream_poly($urandom_range(1, 3), 1'b0);
                    load_set($urandom_range(1, 4), 1'b1);
                    stream_poly($urandom_range(1, 6), 1'b1);
                end
                7:
                begin
                    // run cut short by a fresh set
                    stream_poly($urandom_range(1, 4), 1'b0);
                    load_set(pick_taps(), 1'b1);
                end
                8: load_set($urandom_range(N_TAPS + 1, N_TAPS + 3), 1'b1);
                default:
                    send_item(1'($urandom_range(0, 1)), rand_coef(), rand_coef(),
                              1'($urandom_range(0, 1)));
            endcase
            if (idle_on && $urandom_range(0, 15) == 0)
                drain_pause();
        end

        // --- wind down ---
        in_valid <= 1'b0;
        guard = 0;
        while (book.coefs_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        book.settle();
        if (book.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cpm_pkg.sv
src/cpm_cell.sv
src/complex_polynomial_multiply_core.sv
bench/complex_polynomial_multiply_core_tb.sv
